// File: src/lrub_pkg.sv
// shared types and constants for the retention list with byte budget
// used by lrub_cell, lrub_row and lru_retention_with_byte_budget
package lrub_pkg;

    // must be at least 16: max_entries reaches 15 and one new entry is added on top
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 32;
    localparam int BYTES_W = 36;
    localparam int MAXE_W  = 4;
    localparam int TOT_W   = 5;
    localparam int CIDX_W  = 1;

    localparam logic OP_RETAIN = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_MAX_BYTES   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_TRIM
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } slot_t;

    // broadcast to every cell
    typedef struct packed {
        logic              insert;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
    } cell_ctl_t;

    // handed from one cell to the next along the row
    typedef struct packed {
        logic              seen;
        logic [SIZE_W-1:0] hit_size;
        logic [KEY_W-1:0]  tail_key;
        logic [SIZE_W-1:0] tail_size;
    } cell_chain_t;

endpackage

// File: src/lrub_cell.sv
// one slot of the recency row: holds a key and its byte size
// depends on lrub_pkg
module lrub_cell (
    input  logic                      clk,
    input  logic [lrub_pkg::SLOT_W-1:0] idx,
    input  lrub_pkg::cell_ctl_t       ctl,
    input  lrub_pkg::slot_t           left,
    input  lrub_pkg::cell_chain_t     chain_in,
    output lrub_pkg::slot_t           own,
    output lrub_pkg::cell_chain_t     chain_out,
    output logic                      hit
);

    lrub_pkg::slot_t                 slot_reg;
    logic                            occupied;
    logic                            is_tail;
    logic [lrub_pkg::CNT_W-1:0]      pos;

    assign pos      = lrub_pkg::CNT_W'(idx) + lrub_pkg::CNT_W'(1);
    assign occupied = lrub_pkg::CNT_W'(idx) < ctl.count;
    assign is_tail  = (pos == ctl.count);
    assign hit      = occupied && (slot_reg.key == ctl.key);

    // cells up to and including the matching one (or all of them) shift one place back
    always_ff @(posedge clk)
    begin
        if (ctl.insert && !chain_in.seen)
        begin
            slot_reg <= left;
        end
    end

    always_comb
    begin
        chain_out.seen      = chain_in.seen | hit;
        chain_out.hit_size  = chain_in.hit_size | (hit ? slot_reg.size : '0);
        chain_out.tail_key  = chain_in.tail_key | (is_tail ? slot_reg.key : '0);
        chain_out.tail_size = chain_in.tail_size | (is_tail ? slot_reg.size : '0);
    end

    assign own = slot_reg;

endmodule

// File: src/lrub_row.sv
// row of slot cells, most recent at cell 0, chained for lookup and tail read
// depends on lrub_pkg and lrub_cell
module lrub_row (
    input  logic                        clk,
    input  lrub_pkg::cell_ctl_t         ctl,
    input  lrub_pkg::slot_t             new_slot,
    output logic [lrub_pkg::SLOTS-1:0]  hits,
    output lrub_pkg::cell_chain_t       chain_end
);

    lrub_pkg::slot_t       own   [lrub_pkg::SLOTS];
    lrub_pkg::slot_t       left  [lrub_pkg::SLOTS];
    lrub_pkg::cell_chain_t chain [lrub_pkg::SLOTS+1];

    assign chain[0] = '0;

    for (genvar i = 0; i < lrub_pkg::SLOTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left[i] = new_slot;
        end
        else
        begin : g_body
            assign left[i] = own[i-1];
        end

        lrub_cell u_cell (
            .clk       (clk),
            .idx       (lrub_pkg::SLOT_W'(i)),
            .ctl       (ctl),
            .left      (left[i]),
            .chain_in  (chain[i]),
            .own       (own[i]),
            .chain_out (chain[i+1]),
            .hit       (hits[i])
        );
    end

    assign chain_end = chain[lrub_pkg::SLOTS];

endmodule

// File: src/lru_retention_with_byte_budget.sv
// top level of the recency-ordered retention list with entry and byte limits
// depends on lrub_pkg and lrub_row (which uses lrub_cell)
//
// usage
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 sets
//   max_entries (low 4 bits), index 1 sets max_bytes (36 bits); cfg_ready is
//   always high, write only while the block is idle
//   in channel: one transaction carries operation, key_id and entry_bytes;
//   a retain drops any entry with the same key, puts the new one at the head
//   and then evicts from the tail while over either limit; a clear empties
//   the list
//   out channel: one transaction per evicted entry, or a single no-eviction
//   transaction; last marks the final one for the request
//   timing: a retain is accepted, updates the cell row in ST_UPDATE and then
//   gives one result per cycle while the receiver takes them; the next request
//   is taken only after the final result; a clear gives its result from ST_UPDATE
//   the eviction loop reads one tail cell per cycle unless stalled and sets that rate
//   reset: list empty, max_entries 15, max_bytes all ones; slot contents stay
//   undefined and are never read before written
//   receiver stall: the result waits in the output register and the loop
//   holds until it is taken; after the final result a new request is taken
//   while that result still waits
module lru_retention_with_byte_budget (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lrub_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [lrub_pkg::BYTES_W-1:0]  cfg_data,
    // requests
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [lrub_pkg::KEY_W-1:0]    key_id,
    input  logic [lrub_pkg::SIZE_W-1:0]   entry_bytes,
    // results
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          evicted_valid,
    output logic [lrub_pkg::KEY_W-1:0]    evicted_key,
    output logic [lrub_pkg::SIZE_W-1:0]   evicted_bytes,
    output logic [lrub_pkg::TOT_W-1:0]    entry_total,
    output logic [lrub_pkg::BYTES_W-1:0]  byte_total,
    output logic                          last
);

    // control and totals
    lrub_pkg::state_t                 state_reg, state_next;
    logic [lrub_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [lrub_pkg::BYTES_W-1:0]     bytes_reg, bytes_next;
    logic [lrub_pkg::MAXE_W-1:0]      max_entries_reg, max_entries_next;
    logic [lrub_pkg::BYTES_W-1:0]     max_bytes_reg, max_bytes_next;

    // request held while it is worked on
    logic                             op_reg, op_next;
    logic [lrub_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [lrub_pkg::SIZE_W-1:0]      size_reg, size_next;

    // output register
    logic                             out_valid_reg, out_valid_next;
    logic                             ev_valid_reg, ev_valid_next;
    logic [lrub_pkg::KEY_W-1:0]       ev_key_reg, ev_key_next;
    logic [lrub_pkg::SIZE_W-1:0]      ev_bytes_reg, ev_bytes_next;
    logic [lrub_pkg::TOT_W-1:0]       ent_tot_reg, ent_tot_next;
    logic [lrub_pkg::BYTES_W-1:0]     byte_tot_reg, byte_tot_next;
    logic                             last_reg, last_next;

    // cell row
    lrub_pkg::cell_ctl_t              ctl;
    logic                             row_insert;
    lrub_pkg::slot_t                  new_slot;
    logic [lrub_pkg::SLOTS-1:0]       hits;
    lrub_pkg::cell_chain_t            chain_end;

    logic                             out_free;
    logic                             need;
    logic                             need_after;
    logic [lrub_pkg::CNT_W-1:0]       evict_count;
    logic [lrub_pkg::BYTES_W-1:0]     evict_bytes;
    logic [lrub_pkg::CNT_W-1:0]       limit_count;

    assign new_slot.key  = key_reg;
    assign new_slot.size = size_reg;

    // packed order: insert, key, count
    assign ctl = {row_insert, key_reg, count_reg};

    lrub_row u_row (
        .clk       (clk),
        .ctl       (ctl),
        .new_slot  (new_slot),
        .hits      (hits),
        .chain_end (chain_end)
    );

    // output slot can be loaded when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    // limit checks before and after removing the current tail
    assign limit_count = lrub_pkg::CNT_W'(max_entries_reg);
    assign need        = (count_reg != '0) &&
                         ((count_reg > limit_count) || (bytes_reg > max_bytes_reg));
    assign evict_count = count_reg - lrub_pkg::CNT_W'(1);
    assign evict_bytes = bytes_reg - lrub_pkg::BYTES_W'(chain_end.tail_size);
    assign need_after  = (evict_count != '0) &&
                         ((evict_count > limit_count) || (evict_bytes > max_bytes_reg));

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        max_entries_next = max_entries_reg;
        max_bytes_next   = max_bytes_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lrub_pkg::CFG_MAX_ENTRIES: max_entries_next = cfg_data[lrub_pkg::MAXE_W-1:0];
                lrub_pkg::CFG_MAX_BYTES:   max_bytes_next   = cfg_data;
                default:                   max_bytes_next   = max_bytes_reg;
            endcase
        end
    end

    // sequencer: accept, update the row, then trim from the tail
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        size_next      = size_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ev_valid_next  = ev_valid_reg;
        ev_key_next    = ev_key_reg;
        ev_bytes_next  = ev_bytes_reg;
        ent_tot_next   = ent_tot_reg;
        byte_tot_next  = byte_tot_reg;
        last_next      = last_reg;
        in_ready       = 1'b0;
        row_insert     = 1'b0;

        case (state_reg)
            lrub_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = operation;
                    key_next   = key_id;
                    size_next  = entry_bytes;
                    state_next = lrub_pkg::ST_UPDATE;
                end
            end

            lrub_pkg::ST_UPDATE:
            begin
                if (op_reg == lrub_pkg::OP_CLEAR)
                begin
                    if (out_free)
                    begin
                        count_next     = '0;
                        bytes_next     = '0;
                        out_valid_next = 1'b1;
                        ev_valid_next  = 1'b0;
                        ev_key_next    = '0;
                        ev_bytes_next  = '0;
                        ent_tot_next   = '0;
                        byte_tot_next  = '0;
                        last_next      = 1'b1;
                        state_next     = lrub_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // drop the matching entry and put the new one at the head
                    row_insert = 1'b1;
                    if (!chain_end.seen)
                    begin
                        count_next = count_reg + lrub_pkg::CNT_W'(1);
                    end
                    bytes_next = bytes_reg
                               - lrub_pkg::BYTES_W'(chain_end.hit_size)
                               + lrub_pkg::BYTES_W'(size_reg);
                    state_next = lrub_pkg::ST_TRIM;
                end
            end

            lrub_pkg::ST_TRIM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (need)
                    begin
                        count_next    = evict_count;
                        bytes_next    = evict_bytes;
                        ev_valid_next = 1'b1;
                        ev_key_next   = chain_end.tail_key;
                        ev_bytes_next = chain_end.tail_size;
                        ent_tot_next  = lrub_pkg::TOT_W'(evict_count);
                        byte_tot_next = evict_bytes;
                        last_next     = !need_after;
                        if (!need_after)
                        begin
                            state_next = lrub_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        // nothing over the limits: single no-eviction result
                        ev_valid_next = 1'b0;
                        ev_key_next   = '0;
                        ev_bytes_next = '0;
                        ent_tot_next  = lrub_pkg::TOT_W'(count_reg);
                        byte_tot_next = bytes_reg;
                        last_next     = 1'b1;
                        state_next    = lrub_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = lrub_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lrub_pkg::ST_IDLE;
            count_reg       <= '0;
            bytes_reg       <= '0;
            max_entries_reg <= '1;
            max_bytes_reg   <= '1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            bytes_reg       <= bytes_next;
            max_entries_reg <= max_entries_next;
            max_bytes_reg   <= max_bytes_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        size_reg     <= size_next;
        ev_valid_reg <= ev_valid_next;
        ev_key_reg   <= ev_key_next;
        ev_bytes_reg <= ev_bytes_next;
        ent_tot_reg  <= ent_tot_next;
        byte_tot_reg <= byte_tot_next;
        last_reg     <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_key   = ev_key_reg;
    assign evicted_bytes = ev_bytes_reg;
    assign entry_total   = ent_tot_reg;
    assign byte_total    = byte_tot_reg;
    assign last          = last_reg;

    // between requests the list never fills the whole row
    a_room_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrub_pkg::ST_IDLE) |-> (count_reg < lrub_pkg::CNT_W'(lrub_pkg::SLOTS)))
        else $error("list full between requests");

    // keys in the row are unique, so at most one cell matches
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hits))
        else $error("more than one cell matches the key");

    // a result without an eviction is always the final one
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ev_valid_reg || last_reg))
        else $error("no-eviction result not marked last");

    // a result without an eviction carries zero key and size
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ev_valid_reg) |-> ((ev_key_reg == '0) && (ev_bytes_reg == '0)))
        else $error("no-eviction result carries key or size");

endmodule
